FILE: design/rlp_pkg.sv
// ----------------------------------------------------------------------------
// rlp_pkg: shared types and constants of the run-length text line parser
// Action and status codes, character codes, the byte class that passes from
// the front to the back, and the result record.
// ----------------------------------------------------------------------------
package rlp_pkg;

    // Widths and sizes
    localparam int LINE_COUNTER_BITS = 24;
    localparam int LINE_OUT_W        = 24;
    localparam int WORD_W            = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_DATA_W         = 8;
    localparam int IN_USER_W         = 2;
    localparam int OUT_FIELDS_W      = 3 * WORD_W + LINE_OUT_W + 1;
    localparam int OUT_DATA_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W        = 3;

    localparam logic [WORD_W-1:0] EXPECTED_TOTAL_RESET = 32'd2097152;

    // Character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_F_UP   = 8'h46;

    // Input action codes
    typedef enum logic [1:0] {
        ACT_BYTE   = 2'd0,
        ACT_END    = 2'd1,
        ACT_BEGIN  = 2'd2,
        ACT_IGNORE = 2'd3
    } action_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_COUNT  = 3'd1,
        ST_BAD_VALUE  = 3'd2,
        ST_TRAILING   = 3'd3,
        ST_ZERO_RUN   = 3'd4,
        ST_OVERRUN    = 3'd5,
        ST_EARLY_END  = 3'd6
    } status_t;

    // Layer phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_DONE   = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    // Classified input item
    typedef struct packed {
        action_t    act;
        logic       newline;
        logic       blank;
        logic       hash;
        logic       x_mark;
        logic       dec_ok;
        logic       hex_ok;
        logic [3:0] digit;
    } class_t;

    // One result record
    typedef struct packed {
        status_t                 status;
        logic [WORD_W-1:0]       run_count;
        logic [WORD_W-1:0]       run_value;
        logic [WORD_W-1:0]       placed_total;
        logic [LINE_OUT_W-1:0]   line_in_layer;
        logic                    layer_done;
        logic                    last_in_item;
    } result_t;

endpackage

FILE: design/run_length_text_line_parser.sv
// ----------------------------------------------------------------------------
// run_length_text_line_parser: run list parser for one layer of a text file
// Parses run-count / hex-value lines from a byte stream and returns one run
// record per line that is not skipped, plus an early-end record.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+--------------------------------------------
//  s_      | in  | s_tvalid/s_tready | tdata: text_byte; tuser: action
//  m_      | out | m_tvalid/m_tready | tdata: run fields; tuser: status; tlast
//  cfg_    | in  | cfg_wr_en         | cfg_wr_data: expected_total
//
//  One input beat per cycle while the queue has room; an accepted beat is written
//  to the queue, then the back pops it and decodes it into the result register.
//  End of text that closes a good run short of the total gives two results: the
//  run record, then an early-end record that follows it through the result register.
//  Reset clears all control state and loads expected_total with 2097152.
//  A four-entry queue absorbs output stalls; s_tready drops when it fills.
// ----------------------------------------------------------------------------
module run_length_text_line_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rlp_pkg::IN_DATA_W-1:0]       s_tdata,   // [7:0] text_byte
    input  logic [rlp_pkg::IN_USER_W-1:0]       s_tuser,   // [1:0] action
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] run_count, [63:32] run_value, [95:64] placed_total,
    // [119:96] line_in_layer, [120] layer_done, rest zero
    output logic [rlp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [rlp_pkg::OUT_USER_W-1:0]      m_tuser,   // [2:0] status
    output logic                                m_tlast,   // last_in_item
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [rlp_pkg::WORD_W-1:0]          cfg_wr_data
);

    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    logic               q_full;
    rlp_pkg::class_t    q_item;
    rlp_pkg::class_t    q_head;
    rlp_pkg::result_t   res;

    rlp_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    rlp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    rlp_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    // Pack the result beat
    assign m_tdata = rlp_pkg::OUT_DATA_W'({res.layer_done, res.line_in_layer,
                                           res.placed_total, res.run_value,
                                           res.run_count});
    assign m_tuser = res.status;
    assign m_tlast = res.last_in_item;

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    // An early-end result always closes its input item
    a_early_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == rlp_pkg::ST_EARLY_END)) |-> m_tlast)
        else $error("early-end result not last");

    // Failed results carry no run and never complete the layer
    a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != rlp_pkg::ST_OK)) |->
        ((m_tdata[63:0] == 64'd0) && !m_tdata[120]))
        else $error("error result carries run data");

endmodule

FILE: design/rlp_front.sv
// ----------------------------------------------------------------------------
// rlp_front: input acceptance and byte classification
// Takes one beat per cycle while the queue has room, sorts the byte into
// newline, blank, comment mark, prefix and digit classes, and pushes it unless its action is ignore.
// ----------------------------------------------------------------------------
module rlp_front
(
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rlp_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [rlp_pkg::IN_USER_W-1:0]     s_tuser,
    input  logic                              q_full,
    output logic                              q_push,
    output rlp_pkg::class_t                   q_item
);

    logic [7:0]       ch;
    rlp_pkg::action_t act;

    assign ch  = s_tdata[7:0];
    assign act = rlp_pkg::action_t'(s_tuser[1:0]);

    // Accept whenever the queue has room; drop beats with the ignore action
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && (act != rlp_pkg::ACT_IGNORE);

    // Classify the byte
    always_comb
    begin
        q_item         = '0;
        q_item.act     = act;
        q_item.newline = (ch == rlp_pkg::CH_NL);
        q_item.blank   = (ch == rlp_pkg::CH_SPACE) || (ch == rlp_pkg::CH_TAB) ||
                         (ch == rlp_pkg::CH_CR);
        q_item.hash    = (ch == rlp_pkg::CH_HASH);
        q_item.x_mark  = (ch == rlp_pkg::CH_X_LO) || (ch == rlp_pkg::CH_X_UP);
        q_item.dec_ok  = (ch >= rlp_pkg::CH_0) && (ch <= rlp_pkg::CH_9);
        if ((ch >= rlp_pkg::CH_0) && (ch <= rlp_pkg::CH_9))
        begin
            q_item.hex_ok = 1'b1;
            q_item.digit  = 4'(ch - rlp_pkg::CH_0);
        end
        else if ((ch >= rlp_pkg::CH_A_LO) && (ch <= rlp_pkg::CH_F_LO))
        begin
            q_item.hex_ok = 1'b1;
            q_item.digit  = 4'(ch - rlp_pkg::CH_A_LO + 8'd10);
        end
        else if ((ch >= rlp_pkg::CH_A_UP) && (ch <= rlp_pkg::CH_F_UP))
        begin
            q_item.hex_ok = 1'b1;
            q_item.digit  = 4'(ch - rlp_pkg::CH_A_UP + 8'd10);
        end
    end

endmodule

FILE: design/rlp_queue.sv
// ----------------------------------------------------------------------------
// rlp_queue: short queue between the front and the back
// Holds classified items so that the front keeps accepting while the
// result side stalls.
// ----------------------------------------------------------------------------
module rlp_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rlp_pkg::class_t   push_item,
    input  logic              pop,
    output rlp_pkg::class_t   head,
    output logic              empty,
    output logic              full
);

    rlp_pkg::class_t                  slot_reg [rlp_pkg::QUEUE_DEPTH];
    logic [rlp_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [rlp_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [rlp_pkg::QCNT_W-1:0]       count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == rlp_pkg::QCNT_W'(rlp_pkg::QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == rlp_pkg::QPTR_W'(rlp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rlp_pkg::QPTR_W'(rlp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: design/rlp_back.sv
// ----------------------------------------------------------------------------
// rlp_back: line parser and result register
// Pops one classified item per cycle unless the result side stalls, keeps the
// line's token and accumulator state, checks a finished line, loads the result register.
// ----------------------------------------------------------------------------
module rlp_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [rlp_pkg::WORD_W-1:0]         cfg_wr_data,
    input  rlp_pkg::class_t                    head,
    input  logic                               q_empty,
    output logic                               q_pop,
    output logic                               res_valid,
    input  logic                               res_ready,
    output rlp_pkg::result_t                   res
);

    localparam int LCB = rlp_pkg::LINE_COUNTER_BITS;
    localparam int W   = rlp_pkg::WORD_W;

    rlp_pkg::phase_t     phase_reg, phase_next;
    logic [1:0]          tpos_reg, tpos_next;
    logic                inside_reg, inside_next;
    logic                comment_reg, comment_next;
    logic [W-1:0]        cnt_reg, cnt_next;
    logic                cnt_fault_reg, cnt_fault_next;
    logic [W-1:0]        val_reg, val_next;
    logic                val_fault_reg, val_fault_next;
    logic                val_seen_reg, val_seen_next;
    logic [W-1:0]        covered_reg, covered_next;
    logic [LCB-1:0]      line_reg, line_next;
    logic                pending_reg, pending_next;
    logic                pend_end_reg, pend_end_next;
    logic [W-1:0]        expected_reg;
    logic                out_valid_reg, out_valid_next;
    rlp_pkg::result_t    out_reg, out_next;

    // Token step helpers
    logic                first;
    logic [1:0]          tpos_inc;
    logic                comment_inc;
    logic [W+3:0]        cnt_prod;

    // Line finish helpers
    logic                fin_has;
    rlp_pkg::status_t    fin_status;
    logic [W:0]          fin_sum;
    logic                fin_done;
    logic [LCB-1:0]      line_inc;

    // Event decode
    logic                active;
    logic                fin_applies;
    logic                fin_res;
    logic                res_need;
    logic                out_free;
    logic                do_pop;
    logic                ev_begin, ev_token, ev_fin, ev_end;

    assign out_free = !out_valid_reg || res_ready;
    assign active   = (phase_reg == rlp_pkg::PH_ACTIVE);

    // Decode what the head item does
    always_comb
    begin
        fin_applies = ((head.act == rlp_pkg::ACT_BYTE) && head.newline) ||
                      ((head.act == rlp_pkg::ACT_END) && pending_reg);
        fin_res     = active && fin_applies && fin_has;
        res_need    = active && (((head.act == rlp_pkg::ACT_BYTE) && head.newline &&
                      fin_has) || (head.act == rlp_pkg::ACT_END));
        do_pop      = !q_empty && !pend_end_reg && (out_free || !res_need);
        ev_begin    = do_pop && (head.act == rlp_pkg::ACT_BEGIN);
        ev_fin      = do_pop && active && fin_applies;
        ev_end      = do_pop && active && (head.act == rlp_pkg::ACT_END);
        ev_token    = do_pop && active && (head.act == rlp_pkg::ACT_BYTE) &&
                      !head.newline;
    end

    assign q_pop = do_pop;

    // Evaluate one token byte against the line state
    always_comb
    begin
        first          = !inside_reg;
        tpos_inc       = (first && (tpos_reg != 2'd3)) ? tpos_reg + 2'd1 : tpos_reg;
        comment_inc    = comment_reg || (first && (tpos_reg == 2'd0) && head.hash);
        cnt_prod       = ({4'b0, cnt_reg} << 3) + ({4'b0, cnt_reg} << 1) +
                         (W + 4)'(head.digit);
    end

    // Check the line that is ending
    always_comb
    begin
        fin_has  = (tpos_reg != 2'd0) && !comment_reg;
        fin_sum  = {1'b0, covered_reg} + {1'b0, cnt_reg};
        line_inc = (line_reg == {LCB{1'b1}}) ? line_reg : line_reg + 1'b1;
        priority if (cnt_fault_reg)
        begin
            fin_status = rlp_pkg::ST_BAD_COUNT;
        end
        else if ((tpos_reg < 2'd2) || val_fault_reg || !val_seen_reg)
        begin
            fin_status = rlp_pkg::ST_BAD_VALUE;
        end
        else if (tpos_reg == 2'd3)
        begin
            fin_status = rlp_pkg::ST_TRAILING;
        end
        else if (cnt_reg == '0)
        begin
            fin_status = rlp_pkg::ST_ZERO_RUN;
        end
        else if (fin_sum > {1'b0, expected_reg})
        begin
            fin_status = rlp_pkg::ST_OVERRUN;
        end
        else
        begin
            fin_status = rlp_pkg::ST_OK;
        end
        fin_done = (fin_status == rlp_pkg::ST_OK) && (fin_sum[W-1:0] == expected_reg);
    end

    // Phase next state
    always_comb
    begin
        phase_next = phase_reg;
        priority if (ev_begin)
        begin
            phase_next = (expected_reg == '0) ? rlp_pkg::PH_DONE : rlp_pkg::PH_ACTIVE;
        end
        else if (ev_fin && fin_has && (fin_status != rlp_pkg::ST_OK))
        begin
            phase_next = rlp_pkg::PH_HALT;
        end
        else if (ev_fin && fin_has && fin_done)
        begin
            phase_next = rlp_pkg::PH_DONE;
        end
        else if (ev_end)
        begin
            phase_next = rlp_pkg::PH_HALT;
        end
    end

    // Line state, totals and accumulators
    always_comb
    begin
        tpos_next      = tpos_reg;
        inside_next    = inside_reg;
        comment_next   = comment_reg;
        cnt_next       = cnt_reg;
        cnt_fault_next = cnt_fault_reg;
        val_next       = val_reg;
        val_fault_next = val_fault_reg;
        val_seen_next  = val_seen_reg;
        covered_next   = covered_reg;
        line_next      = line_reg;
        pending_next   = pending_reg;
        pend_end_next  = pend_end_reg;

        if (pend_end_reg && out_free)
        begin
            pend_end_next = 1'b0;
        end

        if (ev_token)
        begin
            pending_next = 1'b1;
            if (head.blank)
            begin
                inside_next = 1'b0;
            end
            else
            begin
                inside_next  = 1'b1;
                tpos_next    = tpos_inc;
                comment_next = comment_inc;
                // Accumulate the count token
                if (!comment_inc && (tpos_inc == 2'd1))
                begin
                    if (!head.dec_ok)
                    begin
                        cnt_fault_next = 1'b1;
                    end
                    else if (!cnt_fault_reg)
                    begin
                        if (cnt_prod[W+3:W] != 4'd0)
                        begin
                            cnt_fault_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next = cnt_prod[W-1:0];
                        end
                    end
                end
                // Accumulate the value token, skipping one leading prefix
                if (!comment_inc && (tpos_inc == 2'd2) && !(first && head.x_mark))
                begin
                    if (!head.hex_ok)
                    begin
                        val_fault_next = 1'b1;
                    end
                    else
                    begin
                        val_seen_next = 1'b1;
                        if (!val_fault_reg)
                        begin
                            if (val_reg[W-1:W-4] != 4'd0)
                            begin
                                val_fault_next = 1'b1;
                            end
                            else
                            begin
                                val_next = {val_reg[W-5:0], head.digit};
                            end
                        end
                    end
                end
            end
        end

        if (ev_fin)
        begin
            line_next = line_inc;
            if (fin_has && (fin_status == rlp_pkg::ST_OK))
            begin
                covered_next = fin_sum[W-1:0];
            end
        end

        // Hold the early-end record behind a good run that did not finish
        if (ev_end && fin_res && (fin_status == rlp_pkg::ST_OK) && !fin_done)
        begin
            pend_end_next = 1'b1;
        end

        // Clear the line after it ends or on begin
        if (ev_fin || ev_begin)
        begin
            tpos_next      = 2'd0;
            inside_next    = 1'b0;
            comment_next   = 1'b0;
            cnt_next       = '0;
            cnt_fault_next = 1'b0;
            val_next       = '0;
            val_fault_next = 1'b0;
            val_seen_next  = 1'b0;
            pending_next   = 1'b0;
        end

        if (ev_begin)
        begin
            covered_next  = '0;
            line_next     = '0;
        end
    end

    // Result record and output register load
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;
        if (pend_end_reg)
        begin
            if (out_free)
            begin
                out_valid_next         = 1'b1;
                out_next               = '0;
                out_next.status        = rlp_pkg::ST_EARLY_END;
                out_next.placed_total  = covered_reg;
                out_next.line_in_layer = rlp_pkg::LINE_OUT_W'(line_reg);
                out_next.last_in_item  = 1'b1;
            end
        end
        else if (do_pop && res_need)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (fin_res)
            begin
                out_next.status        = fin_status;
                out_next.line_in_layer = rlp_pkg::LINE_OUT_W'(line_reg);
                out_next.layer_done    = fin_done;
                out_next.last_in_item  = !((head.act == rlp_pkg::ACT_END) &&
                                           (fin_status == rlp_pkg::ST_OK) && !fin_done);
                if (fin_status == rlp_pkg::ST_OK)
                begin
                    out_next.run_count    = cnt_reg;
                    out_next.run_value    = val_reg;
                    out_next.placed_total = fin_sum[W-1:0];
                end
                else
                begin
                    out_next.placed_total = covered_reg;
                end
            end
            else
            begin
                out_next.status        = rlp_pkg::ST_EARLY_END;
                out_next.placed_total  = covered_reg;
                out_next.line_in_layer = rlp_pkg::LINE_OUT_W'(pending_reg ? line_inc :
                                                              line_reg);
                out_next.last_in_item  = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rlp_pkg::PH_IDLE;
            tpos_reg      <= 2'd0;
            inside_reg    <= 1'b0;
            comment_reg   <= 1'b0;
            cnt_reg       <= '0;
            cnt_fault_reg <= 1'b0;
            val_reg       <= '0;
            val_fault_reg <= 1'b0;
            val_seen_reg  <= 1'b0;
            covered_reg   <= '0;
            line_reg      <= '0;
            pending_reg   <= 1'b0;
            pend_end_reg  <= 1'b0;
            expected_reg  <= rlp_pkg::EXPECTED_TOTAL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tpos_reg      <= tpos_next;
            inside_reg    <= inside_next;
            comment_reg   <= comment_next;
            cnt_reg       <= cnt_next;
            cnt_fault_reg <= cnt_fault_next;
            val_reg       <= val_next;
            val_fault_reg <= val_fault_next;
            val_seen_reg  <= val_seen_next;
            covered_reg   <= covered_next;
            line_reg      <= line_next;
            pending_reg   <= pending_next;
            pend_end_reg  <= pend_end_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                expected_reg <= cfg_wr_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
